[design/wpi_pkg.sv]
// Shared types and constants for the waypoint path interpolator.
package wpi_pkg;

    localparam int DATA_W     = 32;
    localparam int SLOT_W     = 6;
    localparam int PROG_W     = 17;
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 7;
    localparam int CFG_DATA_W = 7;

    localparam logic CFG_PATH_MODE   = 1'b0;
    localparam logic CFG_POINT_COUNT = 1'b1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPLINE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POPOUT = 2'd2;

    typedef enum logic [1:0] {
        KIND_LERP_B,
        KIND_LERP_A,
        KIND_HOLD,
        KIND_SPLINE
    } t_kind;

    typedef struct packed {
        logic                     command;
        logic [SLOT_W-1:0]        point_index;
        logic signed [DATA_W-1:0] point_value;
        logic [PROG_W-1:0]        progress;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] path_value;
        logic                     saturated;
    } t_out_item;

endpackage

[design/waypoint_path_interpolator.sv]
// Waypoint table with linear, Catmull-Rom and pop-out path evaluation.
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One transaction per cycle unless stalled; evaluates pass stages 1-8, then r_out_item.
// The table is two copies with two read ports each: four reads per cycle unless frozen.
// The evaluation runs a Horner chain of five registered multiply stages.
// Reset clears control state only; the table is undefined until loaded.
// An output stall freezes the pipeline only once stage 8 and the output both hold results.
module waypoint_path_interpolator #(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  wpi_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output wpi_pkg::t_out_item                o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [wpi_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import wpi_pkg::*;

    localparam int FB  = FRAC_BITS;
    localparam int TW  = FB + 1;
    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int IW  = $clog2(MAX_POINTS);
    localparam int UW  = TW + NW;
    localparam int SW  = TW + 3;
    localparam int KW  = DATA_W + 4;
    localparam int AW  = 40 + FB;
    localparam int PW  = 2 * FB + 1;
    localparam int XW  = 2 * FB + 2;
    localparam logic [TW-1:0] ONE = TW'(1) << FB;
    localparam logic signed [AW-1:0] MAXV = AW'($signed(32'h7fffffff));
    localparam logic signed [AW-1:0] MINV = AW'($signed(32'h80000000));

    logic adv;
    logic r_out_valid;
    t_out_item r_out_item;

    logic [MODE_W-1:0]  r_mode;
    logic [COUNT_W-1:0] r_count;

    logic [DATA_W-1:0] mem_a [MAX_POINTS];
    logic [DATA_W-1:0] mem_b [MAX_POINTS];

    // accept stage
    logic [NW-1:0] n_eff;
    logic [TW-1:0] t_cl;
    logic [31:0]   prog32;

    // stage 1
    logic              r1_v, r1_eval;
    logic [SLOT_W-1:0] r1_slot;
    logic [DATA_W-1:0] r1_val;
    logic [UW-1:0]     r1_u;
    logic [TW-1:0]     r1_t;
    logic [NW-1:0]     r1_n;
    logic [MODE_W-1:0] r1_mode;

    logic [NW-1:0] s1_seg_raw, s1_seg, s1_nm1, s1_nm2;
    logic [NW:0]   s1_seg2;
    logic [TW-1:0] s1_f;
    logic [SW-1:0] s1_t6;
    logic [IW-1:0] s1_ra, s1_rb, s1_rc, s1_rd;
    t_kind         s1_kind;
    logic [TW-1:0] s1_frac;

    // stage 2
    logic              r2_v;
    t_kind             r2_kind;
    logic [TW-1:0]     r2_f;
    logic [DATA_W-1:0] r_qa, r_qb, r_qc, r_qd;

    logic signed [KW-1:0] s2_a, s2_b, s2_c, s2_d, s2_k3, s2_k2, s2_k1;

    // stage 3..8
    logic                 r3_v, r4_v, r5_v, r6_v, r7_v, r8_v;
    t_kind                r3_kind;
    logic signed [KW-1:0] r3_k3, r3_k2, r3_k1, r3_b, r4_k1, r4_b, r5_k1, r5_b, r6_b, r7_b;
    logic [TW-1:0]        r3_f, r4_f, r5_f, r6_f, r7_f;
    logic signed [AW-1:0] r4_s, r5_s1, r6_v1v, r7_v1, r8_y;
    logic [PW-1:0]        r5_p;
    logic [FB-1:0]        r6_w;
    logic [XW-1:0]        r7_x;

    logic signed [TW:0]   fs3, fs5, fs7;
    logic signed [AW-1:0] s4_pq, s6_x, s8_r;
    logic [FB-1:0]        s6_v0;
    logic [PW-1:0]        s6_wf;

    assign adv         = !r8_v || !r_out_valid || !i_out_stall;
    assign o_in_stall  = !adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_LINEAR;
            r_count <= COUNT_W'(2);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PATH_MODE:   r_mode  <= i_cfg_data[MODE_W-1:0];
                CFG_POINT_COUNT: r_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (32'(r_count) < 32'd2) begin
            n_eff = NW'(2);
        end else if (32'(r_count) > 32'(MAX_POINTS)) begin
            n_eff = NW'(MAX_POINTS);
        end else begin
            n_eff = NW'(r_count);
        end
        prog32 = 32'(i_in_item.progress);
        t_cl   = (prog32 > 32'(ONE)) ? ONE : TW'(prog32);
    end

    // segment, fraction and fetch addresses
    always_comb begin
        s1_nm1     = r1_n - NW'(1);
        s1_nm2     = r1_n - NW'(2);
        s1_seg_raw = NW'(r1_u >> FB);
        s1_seg     = (s1_seg_raw > s1_nm2) ? s1_nm2 : s1_seg_raw;
        s1_f       = TW'(r1_u - (UW'(s1_seg) << FB));
        s1_seg2    = (NW + 1)'(s1_seg) + (NW + 1)'(2);
        s1_t6      = SW'(r1_t) * SW'(6);
        s1_ra      = (s1_seg == '0) ? '0 : IW'(s1_seg - NW'(1));
        s1_rb      = IW'(s1_seg);
        s1_rc      = IW'(s1_seg + NW'(1));
        s1_rd      = (s1_seg2 > (NW + 1)'(s1_nm1)) ? IW'(s1_nm1) : IW'(s1_seg2);
        s1_kind    = KIND_LERP_B;
        s1_frac    = s1_f;
        if (r1_mode == MODE_POPOUT) begin
            s1_ra = IW'(0);
            s1_rc = IW'(2);
            s1_rd = IW'(2);
            if (r1_n != NW'(3)) begin
                s1_rb   = IW'(s1_nm1);
                s1_kind = KIND_HOLD;
            end else begin
                s1_rb = IW'(1);
                if (s1_t6 < SW'(ONE)) begin
                    s1_kind = KIND_LERP_A;
                    s1_frac = TW'(s1_t6);
                end else if (s1_t6 > SW'(ONE) * SW'(5)) begin
                    s1_kind = KIND_LERP_B;
                    s1_frac = TW'(s1_t6 - SW'(ONE) * SW'(5));
                end else begin
                    s1_kind = KIND_HOLD;
                end
            end
        end else if (r1_mode == MODE_SPLINE) begin
            s1_kind = KIND_SPLINE;
        end
    end

    // coefficients from the four fetched points
    always_comb begin
        s2_a  = KW'($signed(r_qa));
        s2_b  = KW'($signed(r_qb));
        s2_c  = KW'($signed(r_qc));
        s2_d  = KW'($signed(r_qd));
        s2_k3 = '0;
        s2_k2 = '0;
        s2_k1 = '0;
        case (r2_kind)
            KIND_SPLINE: begin
                s2_k3 = s2_d - s2_a + 3 * (s2_b - s2_c);
                s2_k2 = 2 * s2_a - 5 * s2_b + 4 * s2_c - s2_d;
                s2_k1 = s2_c - s2_a;
            end
            KIND_LERP_A: begin
                s2_k1 = 2 * (s2_b - s2_a);
                s2_b  = s2_a;
            end
            KIND_LERP_B: s2_k1 = 2 * (s2_c - s2_b);
            default:     s2_k1 = '0;
        endcase
    end

    always_comb begin
        fs3   = $signed({1'b0, r3_f});
        fs5   = $signed({1'b0, r5_f});
        fs7   = $signed({1'b0, r7_f});
        s4_pq = $signed(AW'(r5_p >> FB));
        s6_v0 = r6_v1v[FB-1:0];
        s6_wf = PW'(r6_w) * PW'(r6_f);
        s6_x  = '0;
        s8_r  = r8_y >>> (FB + 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r5_v        <= 1'b0;
            r6_v        <= 1'b0;
            r7_v        <= 1'b0;
            r8_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r1_v <= i_in_valid;
                r2_v <= r1_v && r1_eval;
                r3_v <= r2_v;
                r4_v <= r3_v;
                r5_v <= r4_v;
                r6_v <= r5_v;
                r7_v <= r6_v;
                r8_v <= r7_v;
            end
            if (!r_out_valid || !i_out_stall) begin
                r_out_valid <= r8_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_eval <= (i_in_item.command == CMD_EVAL);
            r1_slot <= i_in_item.point_index;
            r1_val  <= i_in_item.point_value;
            r1_u    <= UW'(t_cl) * UW'(n_eff - NW'(1));
            r1_t    <= t_cl;
            r1_n    <= n_eff;
            r1_mode <= r_mode;

            if (r1_v && !r1_eval && (32'(r1_slot) < 32'(MAX_POINTS))) begin
                mem_a[IW'(r1_slot)] <= r1_val;
                mem_b[IW'(r1_slot)] <= r1_val;
            end
            r_qa    <= mem_a[s1_ra];
            r_qb    <= mem_a[s1_rb];
            r_qc    <= mem_b[s1_rc];
            r_qd    <= mem_b[s1_rd];
            r2_kind <= s1_kind;
            r2_f    <= s1_frac;

            r3_kind <= r2_kind;
            r3_k3   <= s2_k3;
            r3_k2   <= s2_k2;
            r3_k1   <= s2_k1;
            r3_b    <= s2_b;
            r3_f    <= r2_f;

            r4_s  <= r3_k3 * fs3 + (AW'(r3_k2) <<< FB);
            r4_k1 <= r3_k1;
            r4_b  <= r3_b;
            r4_f  <= r3_f;

            r5_s1 <= r4_s >>> FB;
            r5_p  <= PW'(r4_s[FB-1:0]) * PW'(r4_f);
            r5_k1 <= r4_k1;
            r5_b  <= r4_b;
            r5_f  <= r4_f;

            r6_v1v <= r5_s1 * fs5 + (AW'(r5_k1) <<< FB) + s4_pq;
            r6_w   <= r5_p[FB-1:0];
            r6_b   <= r5_b;
            r6_f   <= r5_f;

            r7_v1 <= r6_v1v >>> FB;
            r7_x  <= XW'(PW'(s6_v0) * PW'(r6_f)) + XW'(s6_wf >> FB) + XW'(s6_x);
            r7_b  <= r6_b;
            r7_f  <= r6_f;

            r8_y <= r7_v1 * fs7 + (AW'(r7_b) <<< (FB + 1)) + $signed(AW'(r7_x >> FB));
        end
        if (!r_out_valid || !i_out_stall) begin
            if (s8_r > MAXV) begin
                r_out_item.path_value <= DATA_W'(MAXV);
                r_out_item.saturated  <= 1'b1;
            end else if (s8_r < MINV) begin
                r_out_item.path_value <= DATA_W'(MINV);
                r_out_item.saturated  <= 1'b1;
            end else begin
                r_out_item.path_value <= DATA_W'(s8_r);
                r_out_item.saturated  <= 1'b0;
            end
        end
    end

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r8_v && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input accepted while pipeline is blocked");

    a_fetch_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_qa) && $stable(r_qd) && $stable(r2_kind)))
        else $error("fetched waypoints changed during a freeze");

    a_lerp_no_cubic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r3_v && r3_kind != KIND_SPLINE) |=> (r4_s == '0))
        else $error("cubic terms nonzero outside spline mode");

endmodule

[sim/waypoint_path_interpolator_test.sv]
// Testbench for the waypoint path interpolator: directed and random checks against an internal model.
`timescale 1ns / 100ps

module waypoint_path_interpolator_test;
    import wpi_pkg::*;

    localparam int FRAC         = 16;
    localparam int TABLE_DEPTH  = 64;
    localparam int DRAIN_CYCLES = 14;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam longint ONE_T    = 64'sd1 <<< FRAC;
    localparam longint VAL_MAX  = 64'sd2147483647;
    localparam longint VAL_MIN  = -64'sd2147483648;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_item;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic                  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    logic signed [DATA_W-1:0] waypoint_mirror [TABLE_DEPTH];
    logic [MODE_W-1:0]        mode_mirror;
    logic [COUNT_W-1:0]       count_mirror;
    t_out_item                pending_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int hold_left;
    int error_count;
    int loads_sent;
    int evals_sent;
    int results_seen;
    int clipped_seen;

    waypoint_path_interpolator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic longint floor_q(input longint x);
        return x >>> FRAC;
    endfunction

    function automatic longint waypoint_at(input longint idx);
        return longint'(waypoint_mirror[idx]);
    endfunction

    function automatic longint lerp_q(input longint p0, input longint p1, input longint f);
        return floor_q(p0 * ONE_T + f * (p1 - p0));
    endfunction

    function automatic longint spline_segment(input longint a, input longint b,
                                              input longint c, input longint d,
                                              input longint f);
        longint k3, k2, k1, s, s1, s0, p, pq, v, w, v1, v0, x, y;
        k3 = -a + 3 * b - 3 * c + d;
        k2 = 2 * a - 5 * b + 4 * c - d;
        k1 = c - a;
        s  = k3 * f + k2 * ONE_T;
        s1 = floor_q(s);
        s0 = s - s1 * ONE_T;
        p  = s0 * f;
        pq = floor_q(p);
        v  = s1 * f + k1 * ONE_T + pq;
        w  = p - pq * ONE_T;
        v1 = floor_q(v);
        v0 = v - v1 * ONE_T;
        x  = v0 * f + floor_q(w * f);
        y  = v1 * f + 2 * b * ONE_T + floor_q(x);
        return floor_q(y) >>> 1;
    endfunction

    function automatic t_out_item predict_path(input logic [PROG_W-1:0] prog);
        longint n, t, r, u, seg, f, ia, id, t6;
        t_out_item res;
        n = longint'(count_mirror);
        if (n < 2) n = 2;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        t = longint'(prog);
        if (t > ONE_T) t = ONE_T;
        if (mode_mirror == MODE_POPOUT) begin
            if (n != 3) begin
                r = waypoint_at(n - 1);
            end else begin
                t6 = 6 * t;
                if (t6 < ONE_T)
                    r = lerp_q(waypoint_at(0), waypoint_at(1), t6);
                else if (t6 > 5 * ONE_T)
                    r = lerp_q(waypoint_at(1), waypoint_at(2), t6 - 5 * ONE_T);
                else
                    r = waypoint_at(1);
            end
        end else begin
            u   = t * (n - 1);
            seg = floor_q(u);
            if (seg > n - 2) seg = n - 2;
            f = u - seg * ONE_T;
            if (mode_mirror == MODE_SPLINE) begin
                ia = (seg - 1 < 0) ? 0 : seg - 1;
                id = (seg + 2 > n - 1) ? n - 1 : seg + 2;
                r = spline_segment(waypoint_at(ia), waypoint_at(seg),
                                   waypoint_at(seg + 1), waypoint_at(id), f);
            end else begin
                r = lerp_q(waypoint_at(seg), waypoint_at(seg + 1), f);
            end
        end
        res.saturated = 1'b0;
        if (r > VAL_MAX) begin
            r = VAL_MAX;
            res.saturated = 1'b1;
        end else if (r < VAL_MIN) begin
            r = VAL_MIN;
            res.saturated = 1'b1;
        end
        res.path_value = r[DATA_W-1:0];
        return res;
    endfunction

    function automatic t_in_item load_item(input int slot, input logic [DATA_W-1:0] value);
        t_in_item it;
        it.command     = CMD_LOAD;
        it.point_index = slot[SLOT_W-1:0];
        it.point_value = value;
        it.progress    = PROG_W'($urandom);
        return it;
    endfunction

    function automatic t_in_item eval_item(input int prog);
        t_in_item it;
        it.command     = CMD_EVAL;
        it.point_index = SLOT_W'($urandom);
        it.point_value = $urandom;
        it.progress    = prog[PROG_W-1:0];
        return it;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_item(input t_in_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (it.command == CMD_LOAD) begin
            waypoint_mirror[it.point_index] = it.point_value;
            loads_sent++;
        end else begin
            pending_results.push_back(predict_path(it.progress));
            evals_sent++;
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_PATH_MODE)
            mode_mirror = value[MODE_W-1:0];
        else
            count_mirror = value[COUNT_W-1:0];
    endtask

    task automatic set_path(input logic [MODE_W-1:0] mode, input int count);
        wait_idle();
        write_register(CFG_PATH_MODE, int'(mode));
        write_register(CFG_POINT_COUNT, count);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                t_out_item want;
                want = pending_results.pop_front();
                results_seen++;
                if (o_out_item.saturated) clipped_seen++;
                if (o_out_item.path_value !== want.path_value)
                    report_mismatch("path_value", longint'(o_out_item.path_value),
                                    longint'(want.path_value));
                if (o_out_item.saturated !== want.saturated)
                    report_mismatch("saturated", o_out_item.saturated, want.saturated);
            end
        end
    end

    task automatic test_fill_table();
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(load_item(i, $urandom));
    endtask

    task automatic test_linear_extremes();
        send_item(load_item(0, 32'h8000_0000));
        send_item(load_item(1, 32'h7FFF_FFFF));
        set_path(MODE_LINEAR, 2);
        send_item(eval_item(0));
        send_item(eval_item(1));
        send_item(eval_item(32768));
        send_item(eval_item(65535));
        send_item(eval_item(65536));
        send_item(eval_item(131071));
    endtask

    task automatic test_spline_overshoot();
        send_item(load_item(0, 32'h8000_0000));
        send_item(load_item(1, 32'h7FFF_FFFF));
        send_item(load_item(2, 32'h7FFF_FFFF));
        send_item(load_item(3, 32'h8000_0000));
        set_path(MODE_SPLINE, 4);
        send_item(eval_item(27307));
        send_item(eval_item(32768));
        send_item(eval_item(65536));
        set_path(MODE_SPLINE, 2);
        send_item(eval_item(21845));
        send_item(eval_item(65536));
    endtask

    task automatic test_popout_phases();
        set_path(MODE_POPOUT, 3);
        send_item(eval_item(0));
        send_item(eval_item(10922));
        send_item(eval_item(32768));
        send_item(eval_item(60000));
        send_item(eval_item(65536));
        set_path(MODE_POPOUT, 5);
        send_item(eval_item(30000));
    endtask

    task automatic test_count_limits();
        set_path(MODE_UNUSED, 0);
        send_item(eval_item(40000));
        set_path(MODE_LINEAR, 1);
        send_item(eval_item(40000));
        set_path(MODE_SPLINE, 64);
        send_item(eval_item(65535));
        set_path(MODE_LINEAR, 127);
        send_item(eval_item(65536));
    endtask

    task automatic test_output_hold_off();
        set_path(MODE_SPLINE, 8);
        hold_request = 80;
        for (int i = 0; i < 30; i++)
            send_item(eval_item($urandom_range(0, 65536)));
    endtask

    task automatic test_random_stream(input int items);
        int count;
        int prog;
        logic [DATA_W-1:0] value;
        for (int i = 0; i < items; i++) begin
            if (i % 40 == 0) begin
                count = ($urandom_range(3) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(2, 6);
                set_path(MODE_W'($urandom_range(0, 3)), count);
            end
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(3))
                    0: value = 32'h7FFF_FFFF;
                    1: value = 32'h8000_0000;
                    default: value = $urandom;
                endcase
                send_item(load_item($urandom_range(0, 63), value));
            end else begin
                prog = ($urandom_range(7) == 0) ? $urandom_range(0, 131071)
                                                : $urandom_range(0, 65536);
                send_item(eval_item(prog));
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_in_item     <= '0;
        i_out_stall   <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_PATH_MODE;
        i_cfg_data    <= '0;
        mode_mirror   = MODE_LINEAR;
        count_mirror  = 7'd2;
        hold_request  = 0;
        hold_left     = 0;
        error_count   = 0;
        loads_sent    = 0;
        evals_sent    = 0;
        results_seen  = 0;
        clipped_seen  = 0;
        send_idle_pct = 33;
        recv_idle_pct = 84;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_table();
        test_linear_extremes();
        test_spline_overshoot();
        test_popout_phases();
        test_count_limits();
        test_random_stream(100);
        send_idle_pct = 84;
        recv_idle_pct = 33;
        test_random_stream(100);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_hold_off();
        test_random_stream(100);
        wait_idle();

        $display("Covered %0d loads and %0d evaluations over all path modes and counts.",
                 loads_sent, evals_sent);
        $display("Checked %0d results, %0d of them clipped.", results_seen, clipped_seen);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
